>>> rtl/ptes_pkg.sv
package ptes_pkg;

   localparam int TASKS = 8;
   localparam int TIDX_BITS = 3;
   localparam int TIME_BITS = 16;
   localparam int KEY_BITS = TIME_BITS + 1;
   localparam int CNT_BITS = TIDX_BITS + 1;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic POLICY_EDF = 1'b0;
   localparam logic POLICY_RM = 1'b1;

   typedef struct packed {
      logic [TIME_BITS-1:0] used;
      logic [TIME_BITS-1:0] phase;
      logic [TIME_BITS-1:0] budget;
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] period;
   } task_entry_type;

   typedef struct packed {
      logic eligible;
      logic wrap;
      logic signed [KEY_BITS-1:0] key;
      task_entry_type next_entry;
   } task_eval_type;

endpackage

>>> rtl/periodic_task_edf_rm_scheduler_unit.sv
// Periodic task scheduler with earliest deadline first or rate monotonic selection.
// The req channel carries one item per handshake: tuser selects a table load (0)
// or a time tick (1); tdata holds the slot, period, relative deadline and budget.
// A load writes one table entry and produces no result.
// A tick scans all eight entries, grants the most urgent eligible task, advances
// the phase of every valid entry and then returns one item on the rsp channel with
// the granted slot and an idle flag.
// A tick passes through eight pipelined entry reads, the last compare, a
// read-modify-write of the winner's used count (skipped when no task is granted
// or the winner's phase wraps) and the output register. req_tready returns high
// together with the result, so the next item is not accepted before a tick is done.
// The csr channel writes the policy bit (0 EDF, 1 RM) and is always ready.
// Reset clears all valid bits, the policy and the channel state; table contents
// need no clearing because entries with a clear valid bit are read but ignored.
// When the receiver stalls, the result waits in the output register; loads are
// still accepted, and a further tick is processed but holds its result until the
// output register is free.
module periodic_task_edf_rm_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // task_index [2:0], period [18:3], rel_deadline [34:19], budget [50:35].
   input  logic [55:0] req_tdata,
   // action [0].
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // granted_task [2:0], idle [3].
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_BUMP_RD = 3'd2;
   localparam logic [2:0] ST_BUMP_WR = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam int TB = ptes_pkg::TIME_BITS;

   ptes_pkg::task_entry_type mem [ptes_pkg::TASKS];
   ptes_pkg::task_entry_type mem_rd_data_ff;
   ptes_pkg::task_entry_type mem_wr_data;
   ptes_pkg::task_entry_type load_entry;
   ptes_pkg::task_eval_type  eval;
   logic [ptes_pkg::TIDX_BITS-1:0] mem_rd_addr;
   logic [ptes_pkg::TIDX_BITS-1:0] mem_wr_addr;
   logic                           mem_wr_en;
   logic                           mem_rd_en;

   logic [2:0] state_ff, state_in;
   logic policy_ff, policy_in;
   logic [ptes_pkg::TASKS-1:0] valid_ff, valid_in;
   logic [ptes_pkg::TASKS-1:0] wrap_ff, wrap_in;
   logic [ptes_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic rd_vld_ff, rd_vld_in;
   logic [ptes_pkg::TIDX_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic found_ff, found_in;
   logic [ptes_pkg::TIDX_BITS-1:0] best_ff, best_in;
   logic signed [ptes_pkg::KEY_BITS-1:0] best_key_ff, best_key_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic [ptes_pkg::TIDX_BITS-1:0] req_slot;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign req_slot = req_tdata[2:0];
   assign load_entry.period = req_tdata[18:3];
   assign load_entry.deadline = req_tdata[34:19];
   assign load_entry.budget = req_tdata[50:35];
   assign load_entry.phase = '0;
   assign load_entry.used = '0;

   ptes_task_eval u_eval (
      .entry  (mem_rd_data_ff),
      .policy (policy_ff),
      .eval   (eval)
   );

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         mem_rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_comb begin
      state_in = state_ff;
      policy_in = policy_ff;
      valid_in = valid_ff;
      wrap_in = wrap_ff;
      cnt_in = cnt_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_key_in = best_key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = rd_idx_ff;
      mem_wr_data = eval.next_entry;
      mem_rd_en = 1'b0;
      mem_rd_addr = cnt_ff[ptes_pkg::TIDX_BITS-1:0];

      if (csr_valid && csr_ready) begin
         policy_in = csr_data[0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == ptes_pkg::ACTION_LOAD) begin
                  mem_wr_en = 1'b1;
                  mem_wr_addr = req_slot;
                  mem_wr_data = load_entry;
                  valid_in[req_slot] = 1'b1;
               end else begin
                  state_in = ST_SCAN;
                  cnt_in = '0;
                  found_in = 1'b0;
                  wrap_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff < ptes_pkg::CNT_BITS'(ptes_pkg::TASKS)) begin
               mem_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[ptes_pkg::TIDX_BITS-1:0];
               cnt_in = cnt_ff + ptes_pkg::CNT_BITS'(1);
            end
            if (rd_vld_ff && valid_ff[rd_idx_ff]) begin
               mem_wr_en = 1'b1;
               wrap_in[rd_idx_ff] = eval.wrap;
               if (eval.eligible && (!found_ff || eval.key < best_key_ff)) begin
                  found_in = 1'b1;
                  best_in = rd_idx_ff;
                  best_key_in = eval.key;
               end
            end
            if (rd_vld_ff && rd_idx_ff == ptes_pkg::TIDX_BITS'(ptes_pkg::TASKS - 1)) begin
               state_in = ST_BUMP_RD;
            end
         end
         ST_BUMP_RD: begin
            if (found_ff && !wrap_ff[best_ff]) begin
               mem_rd_en = 1'b1;
               mem_rd_addr = best_ff;
               state_in = ST_BUMP_WR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_BUMP_WR: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = best_ff;
            mem_wr_data = mem_rd_data_ff;
            mem_wr_data.used = mem_rd_data_ff.used + TB'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {4'b0, !found_ff, found_ff ? best_ff : 3'b0};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         policy_ff <= ptes_pkg::POLICY_EDF;
         valid_ff <= '0;
         rd_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         policy_ff <= policy_in;
         valid_ff <= valid_in;
         rd_vld_ff <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      wrap_ff <= wrap_in;
      cnt_ff <= cnt_in;
      rd_idx_ff <= rd_idx_in;
      best_ff <= best_in;
      best_key_ff <= best_key_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> rtl/ptes_task_eval.sv
module ptes_task_eval (
   input  ptes_pkg::task_entry_type entry,
   input  logic                     policy,
   output ptes_pkg::task_eval_type  eval
);

   logic [ptes_pkg::KEY_BITS-1:0] phase_next;
   logic                          wrap;

   assign phase_next = {1'b0, entry.phase} + ptes_pkg::KEY_BITS'(1);
   assign wrap = (phase_next >= {1'b0, entry.period});

   always_comb begin
      eval.eligible = (entry.used < entry.budget);
      eval.wrap = wrap;
      if (policy == ptes_pkg::POLICY_RM) begin
         eval.key = $signed({1'b0, entry.period});
      end else begin
         eval.key = $signed({1'b0, entry.deadline}) - $signed({1'b0, entry.phase});
      end
      eval.next_entry = entry;
      if (wrap) begin
         eval.next_entry.phase = '0;
         eval.next_entry.used = '0;
      end else begin
         eval.next_entry.phase = phase_next[ptes_pkg::TIME_BITS-1:0];
      end
   end

endmodule
